// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they are empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/bdtp_pkg.sv =====
// ---------------------------------------------------------------------------
// bdtp_pkg
// Shared constants, types and the report packing function.
// ---------------------------------------------------------------------------
package bdtp_pkg;

    localparam int MAIN_COUNT   = 8;
    localparam int TURBO_COUNT  = 2;
    localparam int BUTTON_COUNT = MAIN_COUNT + TURBO_COUNT;
    localparam int COUNT_W      = 8;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [COUNT_W-1:0] DEBOUNCE_LIMIT_RESET = 8'd2;
    localparam logic [COUNT_W-1:0] TURBO_PERIOD_RESET   = 8'd3;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_DEBOUNCE_LIMIT = 1'b0,
        REG_TURBO_PERIOD   = 1'b1
    } reg_index_t;

    // Debounced level of one button: the value after the current sample and
    // the value currently held in the register.
    typedef struct packed {
        logic level_next;
        logic level;
    } deb_status_t;

    // Turbo lane output toward the merging stage.
    typedef struct packed {
        logic fire_next;
        logic level;
    } turbo_status_t;

    // Merge debounced main buttons and turbo levels into the report layout:
    // bit 0 a, 1 b, 2 select, 3 start, 4 up, 5 down, 6 left, 7 right.
    function automatic logic [7:0] pack_report(
        input logic [MAIN_COUNT-1:0]  main_level,
        input logic [TURBO_COUNT-1:0] turbo_fire
    );
        logic [7:0] report;
        report[0] = main_level[6] | turbo_fire[0];
        report[1] = main_level[7] | turbo_fire[1];
        report[2] = main_level[4];
        report[3] = main_level[5];
        report[4] = main_level[0];
        report[5] = main_level[1];
        report[6] = main_level[2];
        report[7] = main_level[3];
        return report;
    endfunction

endpackage

// ===== rtl/core/button_debounce_turbo_pack.sv =====
// ---------------------------------------------------------------------------
// button_debounce_turbo_pack
// Ten-button debouncer with two turbo buttons, packed into an 8-bit report.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one raw sample of the active-low pins per
//   transaction: eight main buttons and two turbo buttons. The m_ channel
//   returns one 8-bit report per sample, in order.
//   Ten debounce lanes and two turbo lanes update in the cycle the sample is
//   accepted; the merged report lands in the output register, so it appears
//   on m_ in the cycle after acceptance.
//   Throughput is one sample per cycle. s_ready stays high while the output
//   register is empty or being drained; when the receiver stalls with a
//   report pending, s_ready drops and all lane state holds.
//   The APB port writes debounce_limit at 0x0 and turbo_period at 0x4; write
//   them only while no transaction is in flight.
//   Reset (aresetn low, synchronous) clears all lane state, empties the
//   output register and restores limit 2 and period 3.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_turbo_pack
    import bdtp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_main_pin_levels,
    input  logic [1:0]        s_turbo_pin_levels,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_report_buttons,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [COUNT_W-1:0] debounce_limit_reg;
    logic [COUNT_W-1:0] turbo_period_reg;
    logic               m_valid_reg;
    logic [7:0]         report_reg;
    logic [7:0]         report_next;
    logic               accept;
    logic               cfg_write;
    reg_index_t         cfg_index;

    logic [BUTTON_COUNT-1:0] pressed;
    deb_status_t             deb_status   [BUTTON_COUNT];
    turbo_status_t           turbo_status [TURBO_COUNT];
    logic [MAIN_COUNT-1:0]   main_level_next;
    logic [TURBO_COUNT-1:0]  turbo_fire_next;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= DEBOUNCE_LIMIT_RESET;
            turbo_period_reg   <= TURBO_PERIOD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_DEBOUNCE_LIMIT: debounce_limit_reg <= pwdata[COUNT_W-1:0];
                REG_TURBO_PERIOD:   turbo_period_reg   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_DEBOUNCE_LIMIT: prdata = DATA_W'(debounce_limit_reg);
            REG_TURBO_PERIOD:   prdata = DATA_W'(turbo_period_reg);
            default:            prdata = '0;
        endcase
    end

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    // Pins are active low; lanes work on active-high pressed signals.
    assign pressed = ~{s_turbo_pin_levels, s_main_pin_levels};

    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_deb
        bdtp_debounce_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .sample_en      (accept),
            .pressed        (pressed[i]),
            .debounce_limit (debounce_limit_reg),
            .status         (deb_status[i])
        );
    end

    for (genvar i = 0; i < MAIN_COUNT; i++) begin : g_main
        assign main_level_next[i] = deb_status[i].level_next;
    end

    for (genvar i = 0; i < TURBO_COUNT; i++) begin : g_turbo
        bdtp_turbo_lane u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .sample_en    (accept),
            .held         (deb_status[MAIN_COUNT + i].level_next),
            .turbo_period (turbo_period_reg),
            .status       (turbo_status[i])
        );
        assign turbo_fire_next[i] = turbo_status[i].fire_next;
    end

    assign report_next = pack_report(main_level_next, turbo_fire_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            report_reg <= report_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_report_buttons = report_reg;

    // Every accepted sample leaves a report pending in the next cycle.
    `ASSERT_NEXT(a_accept_fills_output, aclk, aresetn, accept, m_valid_reg)
    // Lane state moves only with an accepted transaction.
    `ASSERT_NEXT(a_deb_hold_when_idle, aclk, aresetn, !accept, $stable(deb_status[0].level))
    // A turbo output can only be active while its button is debounced as held.
    `ASSERT_SAME(a_turbo_a_needs_held, aclk, aresetn, turbo_status[0].level,
                 deb_status[MAIN_COUNT].level)
    `ASSERT_SAME(a_turbo_b_needs_held, aclk, aresetn, turbo_status[1].level,
                 deb_status[MAIN_COUNT + 1].level)

endmodule

// ===== rtl/core/bdtp_debounce_lane.sv =====
// ---------------------------------------------------------------------------
// bdtp_debounce_lane
// Counter debouncer for one active-high pressed signal.
// ---------------------------------------------------------------------------
module bdtp_debounce_lane
    import bdtp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               sample_en,
    input  logic               pressed,
    input  logic [COUNT_W-1:0] debounce_limit,
    output deb_status_t        status
);

    logic               previous_raw_reg;
    logic               previous_raw_next;
    logic [COUNT_W-1:0] stable_count_reg;
    logic [COUNT_W-1:0] stable_count_next;
    logic               level_reg;
    logic               level_next;

    always_comb begin
        stable_count_next = stable_count_reg;
        level_next        = level_reg;
        previous_raw_next = pressed;
        if (pressed != previous_raw_reg) begin
            stable_count_next = '0;
        end else if (stable_count_reg < debounce_limit) begin
            stable_count_next = stable_count_reg + COUNT_W'(1);
        end else begin
            level_next = pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_raw_reg <= 1'b0;
            stable_count_reg <= '0;
            level_reg        <= 1'b0;
        end else if (sample_en) begin
            previous_raw_reg <= previous_raw_next;
            stable_count_reg <= stable_count_next;
            level_reg        <= level_next;
        end
    end

    assign status.level_next = level_next;
    assign status.level      = level_reg;

endmodule

// ===== rtl/core/bdtp_turbo_lane.sv =====
// ---------------------------------------------------------------------------
// bdtp_turbo_lane
// Autofire generator driven by one debounced turbo button.
// ---------------------------------------------------------------------------
module bdtp_turbo_lane
    import bdtp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               sample_en,
    input  logic               held,
    input  logic [COUNT_W-1:0] turbo_period,
    output turbo_status_t      status
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               level_reg;
    logic               level_next;
    logic               last_pressed_reg;

    assign count_inc = count_reg + COUNT_W'(1);

    always_comb begin
        count_next = '0;
        level_next = 1'b0;
        if (held) begin
            if (!last_pressed_reg) begin
                // Press edge fires immediately.
                level_next = 1'b1;
            end else if (count_inc >= turbo_period) begin
                level_next = ~level_reg;
            end else begin
                count_next = count_inc;
                level_next = level_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            level_reg        <= 1'b0;
            last_pressed_reg <= 1'b0;
        end else if (sample_en) begin
            count_reg        <= count_next;
            level_reg        <= level_next;
            last_pressed_reg <= held;
        end
    end

    assign status.fire_next = level_next;
    assign status.level     = level_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ten-button debounce and turbo report packer.
// A short table of pin samples runs first. Random press, bounce and hold
// sequences follow under several debounce and turbo settings. Every report
// is compared with a fixed row value or a cycle-free bench counter model.
// ---------------------------------------------------------------------------
module tb_top;
    import bdtp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_main_pin_levels;
    logic [1:0]        s_turbo_pin_levels;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_report_buttons;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    button_debounce_turbo_pack u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_main_pin_levels  (s_main_pin_levels),
        .s_turbo_pin_levels (s_turbo_pin_levels),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_report_buttons   (m_report_buttons),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 aclk = ~aclk;

    typedef struct packed {
        logic [7:0] main_pins;
        logic [1:0] turbo_pins;
        logic       fixed_valid;
        logic [7:0] fixed_report;
    } sample_row_t;

    typedef struct {
        int limit;
        int period;
        int samples;
        bit hold_off;
    } phase_t;

    // Reset behavior, a full press with both turbos, a held turbo with the
    // main buttons released, contact bounce, and a final release.
    sample_row_t directed_rows [22] = '{
        '{8'hFF, 2'b11, 1'b1, 8'h00}, '{8'hFF, 2'b11, 1'b1, 8'h00},
        '{8'hFF, 2'b11, 1'b1, 8'h00}, '{8'h00, 2'b00, 1'b1, 8'h00},
        '{8'h00, 2'b00, 1'b0, 8'h00}, '{8'h00, 2'b00, 1'b0, 8'h00},
        '{8'h00, 2'b00, 1'b1, 8'hFF}, '{8'hFF, 2'b00, 1'b0, 8'h00},
        '{8'hFF, 2'b00, 1'b0, 8'h00}, '{8'hFF, 2'b00, 1'b0, 8'h00},
        '{8'hFF, 2'b00, 1'b0, 8'h00}, '{8'hFF, 2'b00, 1'b0, 8'h00},
        '{8'hFF, 2'b00, 1'b0, 8'h00}, '{8'hFF, 2'b00, 1'b0, 8'h00},
        '{8'hFF, 2'b00, 1'b0, 8'h00}, '{8'h55, 2'b10, 1'b0, 8'h00},
        '{8'hAA, 2'b01, 1'b0, 8'h00}, '{8'h55, 2'b10, 1'b0, 8'h00},
        '{8'hAA, 2'b01, 1'b0, 8'h00}, '{8'hFF, 2'b11, 1'b0, 8'h00},
        '{8'hFF, 2'b11, 1'b0, 8'h00}, '{8'hFF, 2'b11, 1'b0, 8'h00}
    };

    // Zero settings first, then a receiver hold-off, then the extremes. The
    // long holds at limit 255 and period 255 leave counts running high, so
    // the following phases lower the setting below a running count.
    phase_t phases [6] = '{
        '{0,   0,   120, 1'b0},
        '{1,   1,   150, 1'b0},
        '{4,   2,   150, 1'b1},
        '{255, 1,   260, 1'b0},
        '{1,   255, 280, 1'b0},
        '{0,   1,   100, 1'b0}
    };

    // Bench copy of the configuration and of the per-button state.
    logic [COUNT_W-1:0]      limit_cfg  = DEBOUNCE_LIMIT_RESET;
    logic [COUNT_W-1:0]      period_cfg = TURBO_PERIOD_RESET;
    logic [BUTTON_COUNT-1:0] last_pressed = '0;
    logic [BUTTON_COUNT-1:0] settled      = '0;
    logic [COUNT_W-1:0]      repeat_cnt [BUTTON_COUNT] = '{default: '0};
    logic [COUNT_W-1:0]      fire_cnt   [TURBO_COUNT]  = '{default: '0};
    logic [TURBO_COUNT-1:0]  fire_level   = '0;
    logic [TURBO_COUNT-1:0]  fire_held    = '0;

    logic [7:0] pending_reports [$];
    int         mismatches   = 0;
    int         gapless_left = 0;
    bit         hold_off_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advances the debounce and turbo state by one pin sample and returns
    // the packed report that the sample produces.
    function automatic logic [7:0] debounce_and_pack(input logic [7:0] main_pins,
                                                     input logic [1:0] turbo_pins);
        logic [BUTTON_COUNT-1:0] pressed;
        logic                    held;
        pressed = ~{turbo_pins, main_pins};
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (pressed[i] != last_pressed[i]) begin
                repeat_cnt[i] = '0;
            end else if (repeat_cnt[i] < limit_cfg) begin
                repeat_cnt[i] = repeat_cnt[i] + 1'b1;
            end else begin
                settled[i] = pressed[i];
            end
        end
        last_pressed = pressed;
        for (int t = 0; t < TURBO_COUNT; t++) begin
            held = settled[MAIN_COUNT + t];
            if (!held) begin
                fire_cnt[t]   = '0;
                fire_level[t] = 1'b0;
            end else if (!fire_held[t]) begin
                fire_cnt[t]   = '0;
                fire_level[t] = 1'b1;
            end else begin
                fire_cnt[t] = fire_cnt[t] + 1'b1;
                if (fire_cnt[t] >= period_cfg) begin
                    fire_cnt[t]   = '0;
                    fire_level[t] = ~fire_level[t];
                end
            end
            fire_held[t] = held;
        end
        return {settled[3], settled[2], settled[1], settled[0],
                settled[5], settled[4],
                settled[7] | fire_level[1], settled[6] | fire_level[0]};
    endfunction

    task automatic send_sample(input logic [7:0] main_pins, input logic [1:0] turbo_pins,
                               input logic fixed_valid = 1'b0,
                               input logic [7:0] fixed_report = 8'h00);
        int         gap;
        logic [7:0] predicted;
        if (gapless_left > 0) begin
            gapless_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) gapless_left = $urandom_range(20, 50);
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_main_pin_levels  <= main_pins;
        s_turbo_pin_levels <= turbo_pins;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = debounce_and_pack(main_pins, turbo_pins);
        pending_reports.push_back(fixed_valid ? fixed_report : predicted);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE_LIMIT: limit_cfg  = value;
            REG_TURBO_PERIOD:   period_cfg = value;
            default: ;
        endcase
    endtask

    // Mostly well-formed presses: a little contact bounce, then a hold that
    // is mostly long enough to settle and run the turbo for a few toggles.
    // The rest are short holds that may not settle, and pure noise.
    task automatic run_random_phase(input int samples);
        int         sent;
        int         kind;
        int         hold_len;
        logic [7:0] pad_main;
        logic [1:0] pad_turbo;
        sent = 0;
        while (sent < samples) begin
            kind      = $urandom_range(0, 9);
            pad_main  = 8'($urandom);
            pad_turbo = 2'($urandom);
            if (kind < 2) begin
                repeat ($urandom_range(1, 4)) begin
                    send_sample(8'($urandom), 2'($urandom));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    send_sample(pad_main ^ 8'($urandom), 2'($urandom));
                    sent++;
                end
                if (kind < 8) begin
                    hold_len = int'(limit_cfg) + 1 + $urandom_range(0, 2 * int'(period_cfg) + 3);
                end else begin
                    hold_len = $urandom_range(1, int'(limit_cfg) + 2);
                end
                // A hold never runs past the end of the phase.
                if (hold_len > samples - sent) begin
                    hold_len = (samples > sent) ? samples - sent : 0;
                end
                repeat (hold_len) begin
                    send_sample(pad_main, pad_turbo);
                    sent++;
                end
            end
        end
    endtask

    // Result checker.
    always @(posedge aclk) begin
        logic [7:0] wanted;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected report %02h with no sample pending", m_report_buttons);
                end
            end else begin
                wanted = pending_reports.pop_front();
                if (m_report_buttons !== wanted) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report mismatch: expected %02h, got %02h",
                                 wanted, m_report_buttons);
                    end
                end
            end
        end
    end

    // Receiver: random bursts and gaps, plus one long hold-off on request.
    initial begin
        int burst;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            burst = $urandom_range(1, 40);
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_main_pin_levels  <= 8'hFF;
        s_turbo_pin_levels <= 2'b11;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].main_pins, directed_rows[i].turbo_pins,
                        directed_rows[i].fixed_valid, directed_rows[i].fixed_report);
        end

        foreach (phases[p]) begin
            wait_idle();
            write_reg(REG_DEBOUNCE_LIMIT, COUNT_W'(phases[p].limit));
            write_reg(REG_TURBO_PERIOD, COUNT_W'(phases[p].period));
            // The sender keeps offering samples while the receiver holds off,
            // so the output register fills and the input stalls.
            if (phases[p].hold_off) hold_off_req = 1'b1;
            run_random_phase(phases[p].samples);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
